/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/psum_pkg.sv */
// Package for the prime sum block: microcode word types, step indexes,
// and the control store contents. No dependencies.
`timescale 1ns / 1ps
package psum_pkg;

  localparam int unsigned SUM_BITS    = 21;
  localparam int unsigned FIRST_PRIME = 2;
  localparam int unsigned STEP_BITS   = 4;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EMIT,
    OP_LOAD,
    OP_INITD,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_NEXTD,
    OP_ADD
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_N_GT_LIM,
    C_SQ_GT_N,
    C_CNT_NZ,
    C_REM_Z,
    C_OUT_STALL
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    logic   inc_n;
    step_t  target;
  } ucode_t;

  localparam step_t S_OUT     = step_t'(0);
  localparam step_t S_IDLE    = step_t'(1);
  localparam step_t S_TESTN   = step_t'(2);
  localparam step_t S_INITD   = step_t'(3);
  localparam step_t S_TESTD   = step_t'(4);
  localparam step_t S_DIVINIT = step_t'(5);
  localparam step_t S_DIVSTEP = step_t'(6);
  localparam step_t S_CHECK   = step_t'(7);
  localparam step_t S_NEXTD   = step_t'(8);
  localparam step_t S_PRIME   = step_t'(9);
  localparam step_t S_NEXTN   = step_t'(10);

  // Branch taken: go to target, else fall through to the next step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_OUT:     w = '{OP_EMIT,    C_OUT_STALL, 1'b0, S_OUT};
      S_IDLE:    w = '{OP_LOAD,    C_NO_IN,     1'b0, S_IDLE};
      S_TESTN:   w = '{OP_NONE,    C_N_GT_LIM,  1'b0, S_OUT};
      S_INITD:   w = '{OP_INITD,   C_NEVER,     1'b0, S_IDLE};
      S_TESTD:   w = '{OP_NONE,    C_SQ_GT_N,   1'b0, S_PRIME};
      S_DIVINIT: w = '{OP_DIVINIT, C_NEVER,     1'b0, S_IDLE};
      S_DIVSTEP: w = '{OP_DIVSTEP, C_CNT_NZ,    1'b0, S_DIVSTEP};
      S_CHECK:   w = '{OP_NONE,    C_REM_Z,     1'b0, S_NEXTN};
      S_NEXTD:   w = '{OP_NEXTD,   C_ALWAYS,    1'b0, S_TESTD};
      S_PRIME:   w = '{OP_ADD,     C_NEVER,     1'b0, S_IDLE};
      S_NEXTN:   w = '{OP_NONE,    C_ALWAYS,    1'b1, S_TESTN};
      default:   w = '{OP_NONE,    C_ALWAYS,    1'b0, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/prime_sum_up_to_limit.sv */
// Prime sum up to a limit: microcoded trial-division sequencer.
// Each candidate n is tried against trial divisors d while d*d <= n; each trial
// runs the one-bit-per-cycle remainder unit.
// Throughput: one word at a time; next word taken once the result is taken.
// Reset (rst, synchronous, active high) returns the sequencer to idle, no
// result pending. Uses psum_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prime_sum_up_to_limit #(
  parameter int unsigned LIMIT_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [LIMIT_BITS-1:0]          limit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psum_pkg::SUM_BITS-1:0]  prime_sum
);
  import psum_pkg::*;

  localparam int unsigned NW  = LIMIT_BITS + 1;
  localparam int unsigned SQW = NW + 1;
  localparam int unsigned CW  = $clog2(NW);
  localparam int unsigned SW  = SUM_BITS + 1;

  step_t  pc, pc_next;
  ucode_t uw;
  logic   take;

  logic [LIMIT_BITS-1:0] lim, lim_next;
  logic [NW-1:0]         n, n_next;
  logic [NW-1:0]         d, d_next;
  logic [SQW-1:0]        sq, sq_next;
  logic [NW-1:0]         r, r_next;
  logic [NW-1:0]         qsh, qsh_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [SUM_BITS-1:0]   total, total_next;

  logic [NW:0] rs;
  logic [SW-1:0] sum;

  assign uw        = ucode_rom(pc);
  assign in_stall  = (pc != S_IDLE);
  assign out_valid = (uw.op == OP_EMIT);
  assign prime_sum = total;

  assign rs  = {r, qsh[NW-1]};
  assign sum = SW'(total) + SW'(n);

  always_comb begin
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !in_valid;
      C_N_GT_LIM:  take = (n > NW'(lim));
      C_SQ_GT_N:   take = (sq > SQW'(n));
      C_CNT_NZ:    take = (cnt != '0);
      C_REM_Z:     take = (r == '0);
      C_OUT_STALL: take = out_stall;
      default:     take = 1'b0;
    endcase
    pc_next = take ? uw.target : step_t'(pc + 1'b1);
  end

  always_comb begin
    lim_next   = lim;
    n_next     = uw.inc_n ? NW'(n + 1'b1) : n;
    d_next     = d;
    sq_next    = sq;
    r_next     = r;
    qsh_next   = qsh;
    cnt_next   = cnt;
    total_next = total;
    case (uw.op)
      OP_LOAD: begin
        if (in_valid) begin
          lim_next   = limit;
          n_next     = NW'(FIRST_PRIME);
          total_next = '0;
        end
      end
      OP_INITD: begin
        d_next  = NW'(FIRST_PRIME);
        sq_next = SQW'(FIRST_PRIME * FIRST_PRIME);
      end
      OP_DIVINIT: begin
        r_next   = '0;
        qsh_next = n;
        cnt_next = CW'(NW - 1);
      end
      OP_DIVSTEP: begin
        if (rs >= {1'b0, d}) begin
          r_next = NW'(rs - {1'b0, d});
        end else begin
          r_next = rs[NW-1:0];
        end
        qsh_next = {qsh[NW-2:0], 1'b0};
        cnt_next = CW'(cnt - 1'b1);
      end
      OP_NEXTD: begin
        sq_next = SQW'(sq + {d, 1'b1});
        d_next  = NW'(d + 1'b1);
      end
      OP_ADD: begin
        total_next = (sum > SW'(SUM_MAX)) ? SUM_MAX : sum[SUM_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    lim   <= lim_next;
    n     <= n_next;
    d     <= d_next;
    sq    <= sq_next;
    r     <= r_next;
    qsh   <= qsh_next;
    cnt   <= cnt_next;
    total <= total_next;
  end

  `ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_load_init, clk, rst, in_valid && !in_stall, total == '0 && pc == S_TESTN)
  `ASSERT_IMPL(a_rem_range, clk, rst, pc == S_CHECK, r < d)
  `ASSERT_IMPL(a_div_range, clk, rst, pc == S_TESTD, d >= NW'(FIRST_PRIME) && d <= n)

endmodule

/* dv/prime_sum_up_to_limit_tb.sv */
// Testbench for prime_sum_up_to_limit: directed limits, then random limits under
// varying sender/receiver idling, each result checked against a tabled or trial-division sum.
// Depends on psum_pkg and the prime_sum_up_to_limit RTL.
`timescale 1ns / 1ps
module prime_sum_up_to_limit_tb;
  import psum_pkg::*;

  localparam int unsigned LIMIT_BITS   = 12;
  localparam int unsigned MAX_CYCLES   = 8_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RAND_WORDS   = 28;
  localparam int unsigned NUM_DIR      = 18;

  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    limit_t lim;
    logic   typed;
    sum_t   sum;
  } dir_row_t;

  // typed rows carry a hand-computed sum; the others use prime_sum_of
  dir_row_t dir_tab [NUM_DIR] = '{
    '{limit_t'(0),    1'b1, sum_t'(0)},
    '{limit_t'(1),    1'b1, sum_t'(0)},
    '{limit_t'(2),    1'b1, sum_t'(2)},
    '{limit_t'(3),    1'b1, sum_t'(5)},
    '{limit_t'(4),    1'b1, sum_t'(5)},
    '{limit_t'(5),    1'b1, sum_t'(10)},
    '{limit_t'(7),    1'b1, sum_t'(17)},
    '{limit_t'(10),   1'b1, sum_t'(17)},
    '{limit_t'(11),   1'b1, sum_t'(28)},
    '{limit_t'(13),   1'b1, sum_t'(41)},
    '{limit_t'(25),   1'b1, sum_t'(100)},
    '{limit_t'(48),   1'b0, sum_t'(0)},
    '{limit_t'(49),   1'b0, sum_t'(0)},
    '{limit_t'(97),   1'b0, sum_t'(0)},
    '{limit_t'(121),  1'b0, sum_t'(0)},
    '{limit_t'(169),  1'b0, sum_t'(0)},
    '{limit_t'(256),  1'b0, sum_t'(0)},
    '{limit_t'(4095), 1'b0, sum_t'(0)}
  };

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  limit_t limit     = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  sum_t   prime_sum;

  logic   word_typed = 1'b0;
  sum_t   word_sum   = '0;
  sum_t   sum_q [$];
  sum_t   exp_sum;

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned send_idle  = 10;
  int unsigned recv_idle  = 82;
  int unsigned rand_idx   = 0;

  always #4 clk = ~clk;

  prime_sum_up_to_limit #(
    .LIMIT_BITS(LIMIT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .limit    (limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prime_sum(prime_sum)
  );

  function automatic sum_t prime_sum_of(limit_t lim);
    int unsigned total;
    int unsigned n;
    int unsigned d;
    bit          composite;
    total = 0;
    for (n = FIRST_PRIME; n <= lim; n++) begin
      composite = 1'b0;
      for (d = FIRST_PRIME; d * d <= n && !composite; d++)
        if (n % d == 0) composite = 1'b1;
      if (!composite) total += n;
    end
    return (total > SUM_MAX) ? SUM_MAX : sum_t'(total);
  endfunction

  // mostly small limits; the block is slow on large ones
  function automatic limit_t pick_limit(int unsigned idx);
    if (idx % 40 == 17) return limit_t'($urandom_range(767, 256));
    if ($urandom_range(9) == 0) return limit_t'($urandom_range(255, 64));
    return limit_t'($urandom_range(63, 0));
  endfunction

  task automatic send_word(limit_t lim, logic typed, sum_t sum);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    limit      <= lim;
    word_typed <= typed;
    word_sum   <= sum;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_word(pick_limit(rand_idx), 1'b0, '0);
      rand_idx++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sum_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sum_q.push_back(word_typed ? word_sum : prime_sum_of(limit));
      if (out_valid && !out_stall) begin
        if (sum_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: prime_sum=%0d", prime_sum);
        end else begin
          exp_sum = sum_q.pop_front();
          if (prime_sum !== exp_sum) begin
            mismatches++;
            if (mismatches <= 10)
              $display("prime_sum mismatch: expected %0d, got %0d", exp_sum, prime_sum);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_word(dir_tab[i].lim, dir_tab[i].typed, dir_tab[i].sum);
    send_random(RAND_WORDS);
    // hold off until every result is back
    wait_drained();

    send_idle = 82;
    recv_idle = 10;
    send_random(RAND_WORDS);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    send_random(RAND_WORDS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && sum_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
